>>> src/ptle_pkg.sv
// types and constants shared by the peer table blocks
// no dependencies

package ptle_pkg;

  localparam logic ACT_TOUCH  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] node_id;
    logic [31:0] now_ms;
  } ptle_req_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic        hit;
    logic        added;
    logic        evicted;
    logic [15:0] evicted_id;
    logic [6:0]  entry_count;
  } ptle_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } ptle_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } ptle_ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_empty;
    logic scan_last;
  } ptle_stat_t;

endpackage

>>> src/ptle_ctrl.sv
// sequencing state machine for the peer table scan
// depends on ptle_pkg

module ptle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ptle_pkg::ptle_stat_t stat_i,
  output ptle_pkg::ptle_ctrl_t ctrl_o,
  output logic                busy_o
);
  import ptle_pkg::*;

  ptle_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = stat_i.scan_empty ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o      = 1'b0;
        ctrl_o.load = start_i;
      end
      ST_SCAN:   ctrl_o.issue  = 1'b1;
      ST_DRAIN:  ctrl_o.issue  = 1'b0;
      ST_DECIDE: ctrl_o.finish = 1'b1;
      default:   busy_o        = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  property p_accept_goes_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      (start_i && !busy_o) |=> busy_o;
  endproperty
  a_accept_goes_busy: assert property (p_accept_goes_busy)
    else $error("accepted transaction did not raise busy");

  property p_decide_after_scan;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_DECIDE) |-> ($past(state_q) == ST_DRAIN || $past(state_q) == ST_IDLE);
  endproperty
  a_decide_after_scan: assert property (p_decide_after_scan)
    else $error("decision reached without completing the scan");

endmodule

>>> src/ptle_dp.sv
// datapath: id/time storage, scan compare, decision and result register
// depends on ptle_pkg

module ptle_dp #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptle_pkg::ptle_req_t  req_i,
  input  ptle_pkg::ptle_ctrl_t ctrl_i,
  output ptle_pkg::ptle_stat_t stat_o,
  output logic                valid_o,
  output ptle_pkg::ptle_rsp_t  rsp_o
);
  import ptle_pkg::*;

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] Full = CntW'(TABLE_ENTRIES);

  logic [15:0] id_mem   [TABLE_ENTRIES];
  logic [31:0] time_mem [TABLE_ENTRIES];

  ptle_req_t       req_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] ptr_q;

  logic [15:0]     rd_id_q;
  logic [31:0]     rd_time_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            rd_vld_q;

  logic            found_q;
  logic [IdxW-1:0] match_q;
  logic [31:0]     min_time_q;
  logic [IdxW-1:0] min_slot_q;
  logic [15:0]     min_id_q;

  logic            valid_q;
  ptle_rsp_t       rsp_q, rsp_d;

  logic            we_id, we_time;
  logic [IdxW-1:0] waddr;
  logic            touch, full;

  assign stat_o.scan_empty = (cnt_q == '0);
  assign stat_o.scan_last  = ((CntW'(ptr_q) + CntW'(1)) == cnt_q);

  // registered memory read, one entry per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      rd_id_q   <= id_mem[ptr_q];
      rd_time_q <= time_mem[ptr_q];
    end
    rd_idx_q <= ptr_q;
    if (we_id) begin
      id_mem[waddr] <= req_q.node_id;
    end
    if (we_time) begin
      time_mem[waddr] <= req_q.now_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      ptr_q    <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      rd_vld_q <= ctrl_i.issue;
      valid_q  <= ctrl_i.finish;
      cnt_q    <= cnt_d;
      if (ctrl_i.load) begin
        ptr_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (ctrl_i.issue) begin
          ptr_q <= ptr_q + IdxW'(1);
        end
        if (rd_vld_q && !found_q && rd_id_q == req_q.node_id) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q <= req_i;
    end
    if (rd_vld_q && !found_q && rd_id_q == req_q.node_id) begin
      match_q <= rd_idx_q;
    end
    // oldest entry so far, ties keep the lower slot
    if (rd_vld_q && (rd_idx_q == '0 || rd_time_q < min_time_q)) begin
      min_time_q <= rd_time_q;
      min_slot_q <= rd_idx_q;
      min_id_q   <= rd_id_q;
    end
    if (ctrl_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign touch = (req_q.action == ACT_TOUCH);
  assign full  = (cnt_q == Full);

  always_comb begin
    we_id   = 1'b0;
    we_time = 1'b0;
    waddr   = match_q;
    cnt_d   = cnt_q;
    rsp_d   = '0;
    rsp_d.hit = found_q;
    if (found_q) begin
      rsp_d.slot = 6'(match_q);
    end
    if (ctrl_i.finish && touch) begin
      we_time = 1'b1;
      if (!found_q) begin
        we_id = 1'b1;
        if (!full) begin
          waddr       = cnt_q[IdxW-1:0];
          cnt_d       = cnt_q + CntW'(1);
          rsp_d.slot  = 6'(cnt_q[IdxW-1:0]);
          rsp_d.added = 1'b1;
        end else begin
          waddr            = min_slot_q;
          rsp_d.slot       = 6'(min_slot_q);
          rsp_d.evicted    = 1'b1;
          rsp_d.evicted_id = min_id_q;
        end
      end
    end
    rsp_d.entry_count = 7'(cnt_d);
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  property p_count_bounded;
    @(posedge clk_i) disable iff (!rst_ni)
      cnt_q <= Full;
  endproperty
  a_count_bounded: assert property (p_count_bounded)
    else $error("entry count beyond table size");

  property p_issue_in_range;
    @(posedge clk_i) disable iff (!rst_ni)
      ctrl_i.issue |-> (CntW'(ptr_q) < cnt_q);
  endproperty
  a_issue_in_range: assert property (p_issue_in_range)
    else $error("scan read beyond valid entries");

  property p_one_outcome;
    @(posedge clk_i) disable iff (!rst_ni)
      valid_q |-> ($countones({rsp_q.hit, rsp_q.added, rsp_q.evicted}) <= 1);
  endproperty
  a_one_outcome: assert property (p_one_outcome)
    else $error("result reports more than one outcome");

endmodule

>>> src/peer_table_lru_evict.sv
// top level of the peer table with least recently seen eviction
// depends on ptle_pkg, ptle_ctrl, ptle_dp
//
//   channel  | handshake           | payload
//   request  | start in, busy out  | req_i: action, node_id, now_ms
//   result   | valid_o out, strobe | rsp_o: slot, hit, added, evicted, evicted_id, entry_count
//
// with entries in the table an accepted request passes the scan, drain and decide states before the
// result strobe (an empty table goes straight to decide); the scan reads one table entry per cycle
// busy drops in the cycle the result is shown, so the next start can be taken then
// reset clears the entry count and the controller; table contents need no reset
// results cannot be stalled by the receiver

module peer_table_lru_evict #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ptle_pkg::ptle_req_t req_i,
  output logic               valid_o,
  output ptle_pkg::ptle_rsp_t rsp_o
);
  import ptle_pkg::*;

  ptle_ctrl_t ctrl;
  ptle_stat_t stat;

  ptle_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  ptle_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

endmodule

>>> test/peer_table_lru_evict_test.sv
// testbench for peer_table_lru_evict: directed and random touch and lookup transactions,
// checked against a behavioral copy of the peer table kept in the testbench
// depends on ptle_pkg and peer_table_lru_evict

module peer_table_lru_evict_test;
  import ptle_pkg::*;

  localparam int TABLE_ENTRIES = 8;
  localparam int RANDOM_ITEMS = 750;
  localparam int MAX_REPORTS = 10;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  ptle_req_t req_i;
  logic      valid_o;
  ptle_rsp_t rsp_o;

  peer_table_lru_evict #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  ptle_req_t   pending_reqs[$];
  ptle_rsp_t   expected_rsps[$];
  logic [15:0] peer_ids[TABLE_ENTRIES];
  logic [31:0] peer_seen[TABLE_ENTRIES];
  int          peer_count;
  int          fail_cnt;
  int          issued_cnt;
  bit          req_taken;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // behavioral peer table: lowest matching slot, append while room, else oldest entry
  function automatic ptle_rsp_t predict_peer_action(ptle_req_t req);
    ptle_rsp_t rsp;
    int        match;
    int        victim;
    rsp = '0;
    match = -1;
    for (int i = 0; i < peer_count; i++) begin
      if (match < 0 && peer_ids[i] == req.node_id) match = i;
    end
    if (match >= 0) begin
      rsp.hit = 1'b1;
      rsp.slot = 6'(match);
    end
    if (req.action == ACT_TOUCH) begin
      if (match < 0) begin
        if (peer_count < TABLE_ENTRIES) begin
          victim = peer_count;
          peer_count++;
          rsp.added = 1'b1;
        end else begin
          victim = 0;
          for (int i = 1; i < TABLE_ENTRIES; i++) begin
            if (peer_seen[i] < peer_seen[victim]) victim = i;
          end
          rsp.evicted = 1'b1;
          rsp.evicted_id = peer_ids[victim];
        end
        peer_ids[victim] = req.node_id;
        match = victim;
        rsp.slot = 6'(victim);
      end
      peer_seen[match] = req.now_ms;
    end
    rsp.entry_count = 7'(peer_count);
    return rsp;
  endfunction

  function automatic bit idle_now();
    if (issued_cnt >= 300 && issued_cnt < 450) return 1'b0;
    return $urandom_range(99) < 38;
  endfunction

  task automatic add_req(logic action, logic [15:0] node_id, logic [31:0] now_ms);
    ptle_req_t req;
    req.action = action;
    req.node_id = node_id;
    req.now_ms = now_ms;
    pending_reqs.push_back(req);
  endtask

  // driver: hold a request until it is taken, idle at random between transactions
  always @(negedge clk_i) begin
    bit          hold;
    logic [63:0] noise;
    hold = start && !req_taken;
    noise = {$urandom, $urandom};
    if (start && req_taken) begin
      pending_reqs.delete(0);
      issued_cnt++;
    end
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else if (hold) begin
      start <= 1'b1;
    end else if (pending_reqs.size() != 0 && !idle_now()) begin
      start <= 1'b1;
      req_i <= pending_reqs[0];
    end else begin
      start <= 1'b0;
      req_i <= noise[$bits(ptle_req_t)-1:0];
    end
  end

  // monitor: check results first, then predict the transaction taken at this edge
  always @(posedge clk_i) begin
    ptle_rsp_t want;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (valid_o) begin
        if (expected_rsps.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) $display("unexpected result %p", rsp_o);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_o.slot !== want.slot || rsp_o.hit !== want.hit ||
              rsp_o.added !== want.added || rsp_o.evicted !== want.evicted ||
              rsp_o.evicted_id !== want.evicted_id ||
              rsp_o.entry_count !== want.entry_count) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS) begin
              $display("mismatch: expected %p", want);
              $display("          actual   %p", rsp_o);
            end
          end
        end
      end
      if (start && !busy) begin
        expected_rsps.push_back(predict_peer_action(req_i));
        req_taken = 1'b1;
      end
    end
  end

  initial begin
    logic [15:0] id_pool[12];
    logic [31:0] clock_ms;
    logic [15:0] node_id;
    logic        action;
    int          pick;
    rst_ni = 1'b0;

    // empty table, extremes of id and time, fill with tied times, then evictions
    add_req(ACT_LOOKUP, 16'h1234, 32'd5);
    add_req(ACT_TOUCH, 16'h0000, 32'h0000_0000);
    add_req(ACT_TOUCH, 16'hffff, 32'hffff_ffff);
    add_req(ACT_LOOKUP, 16'hffff, 32'h0000_0000);
    add_req(ACT_LOOKUP, 16'h0000, 32'hffff_ffff);
    add_req(ACT_TOUCH, 16'h0000, 32'd100);
    for (int i = 1; i <= 6; i++) add_req(ACT_TOUCH, 16'(i), 32'd100);
    add_req(ACT_TOUCH, 16'h0007, 32'd100);        // all tied but one: lowest slot goes
    add_req(ACT_LOOKUP, 16'h0000, 32'd100);       // evicted id is gone
    add_req(ACT_TOUCH, 16'habcd, 32'h0000_0000);
    add_req(ACT_TOUCH, 16'h5555, 32'd50);
    add_req(ACT_LOOKUP, 16'hffff, 32'hffff_ffff);
    add_req(ACT_TOUCH, 16'hffff, 32'd1);          // hit restamps to an older time
    add_req(ACT_TOUCH, 16'haaaa, 32'd2);
    add_req(ACT_LOOKUP, 16'haaaa, 32'h8000_0000);
    add_req(ACT_TOUCH, 16'h5555, 32'hffff_ffff);

    // random: ids mostly from a small pool so hits, misses and evictions all occur
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    clock_ms = 32'd1000;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) id_pool[$urandom_range(11)] = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 5) clock_ms = $urandom;
      else if (pick >= 8) clock_ms = clock_ms + $urandom_range(1000, 1);
      node_id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(11)] : 16'($urandom);
      action = ($urandom_range(99) < 30) ? ACT_LOOKUP : ACT_TOUCH;
      add_req(action, node_id, clock_ms);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_reqs.size() == 0);
    wait (expected_rsps.size() == 0);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && expected_rsps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
src/ptle_pkg.sv
src/ptle_ctrl.sv
src/ptle_dp.sv
src/peer_table_lru_evict.sv
test/peer_table_lru_evict_test.sv
